// ----- hdl/cpts_pkg.sv -----
// ---------------------------------------------------------------------------
// cpts_pkg: shared types for the counter/priority task scheduler
// Transfer structs, mode codes and controller states.
// ---------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

  localparam logic MODE_CREATE = 1'b0;
  localparam logic MODE_SCHED  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [3:0] priority_req;
  } cpts_req_t;

  typedef struct packed {
    logic [5:0] task_id;
    logic       pool_full;
    logic       switched;
  } cpts_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_SCAN,
    ST_SCAN_END,
    ST_REFR,
    ST_REFR_END
  } cpts_state_e;

endpackage

`default_nettype wire

// ----- hdl/counter_priority_task_scheduler.sv -----
// ---------------------------------------------------------------------------
// counter_priority_task_scheduler: counter/goodness task slot scheduler
// Task slot table with create and schedule commands over one slot memory.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: req_i is taken at a rising edge with start_i high and
//   busy_o low. busy_o stays high until the result has been produced.
//   Result channel: rsp_o is valid for exactly one cycle while done_o is
//   high; the receiver cannot stall it.
//   Create walks the running flags from slot 1 upward, one slot a cycle.
//   Schedule streams the slot memory (priority, counter) from the highest
//   slot down through its registered read port; when every running counter
//   is zero, a refresh pass rewrites the counters and picks the winner on
//   the way.
//   A new command may be started in the cycle done_o is high.
//   Reset: only slot 0 runs, with priority 1 and counter 1, current task 0.
//   Memory contents need no clearing pass; the running flags qualify them.
// ---------------------------------------------------------------------------
`default_nettype none

module counter_priority_task_scheduler
  import cpts_pkg::*;
#(
  parameter int NUM_TASKS = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire cpts_req_t req_i,
  output logic           done_o,
  output cpts_rsp_t      rsp_o
);

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_TASKS - 1);

  cpts_state_e state_q, state_d;

  logic [IW-1:0]        idx_q, idx_d;
  logic                 p_vld_q;
  logic [IW-1:0]        p_idx_q;
  logic [7:0]           rd_q;
  logic [3:0]           best_q;
  logic [IW-1:0]        best_slot_q;
  logic                 have_q;
  logic [IW-1:0]        cur_q;
  logic [3:0]           prio_q;
  logic                 s0_wr_q;
  logic [NUM_TASKS-1:0] running_q;
  logic                 done_q;
  cpts_rsp_t            rsp_q;

  logic [7:0] mem_q [NUM_TASKS];

  logic          accept;
  logic          issue;
  logic          refr_phase;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [3:0]    e_prio, e_cnt, new_cnt, val;
  logic [4:0]    sum;
  logic          e_run, take;
  logic [3:0]    best_nxt;
  logic [IW-1:0] best_slot_nxt;
  logic          fin_create, fin_full, fin_sched;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Slot data as seen by the processing stage; slot 0 holds {1,1} until written.
  always_comb begin
    if ((p_idx_q == '0) && !s0_wr_q) begin
      e_prio = 4'd1;
      e_cnt  = 4'd1;
    end else begin
      e_prio = rd_q[7:4];
      e_cnt  = rd_q[3:0];
    end
    e_run   = running_q[p_idx_q];
    sum     = {2'b0, e_cnt[3:1]} + {1'b0, e_prio};
    new_cnt = sum[4] ? 4'hF : sum[3:0];
    val     = refr_phase ? new_cnt : e_cnt;
    take    = p_vld_q && e_run && (!have_q || (val > best_q));
    best_nxt      = take ? val : best_q;
    best_slot_nxt = take ? p_idx_q : best_slot_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (req_i.mode == MODE_CREATE) ? ST_CREATE : ST_SCAN;
        end
      end
      ST_CREATE: begin
        if (!running_q[idx_q] || (idx_q == LAST)) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (idx_q == '0) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_d = (best_nxt == 4'd0) ? ST_REFR : ST_IDLE;
      ST_REFR: begin
        if (idx_q == '0) begin
          state_d = ST_REFR_END;
        end
      end
      ST_REFR_END: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    issue      = 1'b0;
    refr_phase = 1'b0;
    fin_create = 1'b0;
    fin_full   = 1'b0;
    fin_sched  = 1'b0;
    idx_d      = idx_q;
    mem_we     = 1'b0;
    mem_waddr  = p_idx_q;
    mem_wdata  = {e_prio, new_cnt};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = (req_i.mode == MODE_CREATE) ? IW'(1) : LAST;
        end
      end
      ST_CREATE: begin
        if (!running_q[idx_q]) begin
          fin_create = 1'b1;
          mem_we     = 1'b1;
          mem_waddr  = idx_q;
          mem_wdata  = {prio_q, prio_q};
        end else if (idx_q == LAST) begin
          fin_full = 1'b1;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        idx_d = idx_q - IW'(1);
      end
      ST_SCAN_END: begin
        fin_sched = (best_nxt != 4'd0);
        idx_d     = LAST;
      end
      ST_REFR: begin
        issue      = 1'b1;
        refr_phase = 1'b1;
        idx_d      = idx_q - IW'(1);
        mem_we     = p_vld_q && e_run;
      end
      ST_REFR_END: begin
        refr_phase = 1'b1;
        fin_sched  = 1'b1;
        mem_we     = p_vld_q && e_run;
      end
      default: ;
    endcase
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i) begin
    p_idx_q <= idx_q;
    if (fin_create) begin
      rsp_q <= '{task_id: 6'(idx_q), pool_full: 1'b0, switched: 1'b0};
    end else if (fin_full) begin
      rsp_q <= '{task_id: 6'd0, pool_full: 1'b1, switched: 1'b0};
    end else if (fin_sched) begin
      rsp_q <= '{task_id: 6'(best_slot_nxt), pool_full: 1'b0,
                 switched: (best_slot_nxt != cur_q)};
    end
    if (accept) begin
      prio_q <= req_i.priority_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      p_vld_q     <= 1'b0;
      best_q      <= '0;
      best_slot_q <= '0;
      have_q      <= 1'b0;
      cur_q       <= '0;
      s0_wr_q     <= 1'b0;
      running_q   <= NUM_TASKS'(1);
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      p_vld_q <= issue;
      done_q  <= fin_create || fin_full || fin_sched;
      if (accept) begin
        have_q      <= 1'b0;
        best_q      <= '0;
        best_slot_q <= '0;
      end else begin
        have_q      <= have_q || take;
        best_q      <= best_nxt;
        best_slot_q <= best_slot_nxt;
      end
      if (fin_create) begin
        running_q[idx_q] <= 1'b1;
      end
      if (mem_we && (mem_waddr == '0)) begin
        s0_wr_q <= 1'b1;
      end
      if (fin_sched) begin
        cur_q <= best_slot_nxt;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("command transfer did not raise busy");

  a_slot0_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q[0])
    else $error("slot 0 lost its running flag");

  a_rsp_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.pool_full && rsp_o.switched))
    else $error("result flags pool_full and switched both set");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

endmodule

`default_nettype wire
